// File: src/npcl1_pkg.sv
// ----------------------------------------------------------------------------
// npcl1_pkg: shared types and constants for the nearest palette color search
// Token carried along the cell chain, item kinds and the channel distance helper.
// ----------------------------------------------------------------------------
package npcl1_pkg;

  // Number of palette cells in the chain (2..256)
  localparam int unsigned PALETTE_DEPTH = 256;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned COUNT_W = 9;
  // Largest L1 distance is 3 * 255 = 765
  localparam int unsigned DIST_W  = 10;

  localparam logic [COUNT_W-1:0] ENTRIES_RESET = 9'd256;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_PIXEL = 1'b1
  } kind_e;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  // Item moving down the chain, with the best match found so far
  typedef struct packed {
    kind_e              kind;
    logic [INDEX_W-1:0] entry_index;
    rgb_t               color;
    logic               found;
    logic [DIST_W-1:0]  best_dist;
    logic [INDEX_W-1:0] best_idx;
  } token_t;

  function automatic logic [CHAN_W-1:0] abs_diff8(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] res;
    if (a > b) begin
      res = a - b;
    end else begin
      res = b - a;
    end
    return res;
  endfunction

endpackage

// File: src/npcl1_cell.sv
// ----------------------------------------------------------------------------
// npcl1_cell: one palette cell of the search chain
// Holds one palette entry, writes it on a matching load, scores passing pixels
// against it and registers the token for the next cell.
// ----------------------------------------------------------------------------
module npcl1_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                advance_i,
  input  logic [npcl1_pkg::INDEX_W-1:0]       cell_id_i,
  input  logic [npcl1_pkg::COUNT_W-1:0]       entries_i,
  input  logic                                tok_valid_i,
  input  npcl1_pkg::token_t                   tok_i,
  output logic                                tok_valid_o,
  output npcl1_pkg::token_t                   tok_o
);

  npcl1_pkg::rgb_t              entry_q;
  npcl1_pkg::token_t            tok_d, tok_q;
  logic                         valid_q;
  logic                         active;
  logic [npcl1_pkg::DIST_W-1:0] l1_dist;
  logic                         take;
  logic                         write_en;

  // Cells at or past the configured count take no part in the search
  assign active = ({1'b0, cell_id_i} < entries_i);

  assign l1_dist = npcl1_pkg::DIST_W'(npcl1_pkg::abs_diff8(tok_i.color.red,   entry_q.red))
                 + npcl1_pkg::DIST_W'(npcl1_pkg::abs_diff8(tok_i.color.green, entry_q.green))
                 + npcl1_pkg::DIST_W'(npcl1_pkg::abs_diff8(tok_i.color.blue,  entry_q.blue));

  // strict less-than keeps the lowest index on a tie
  assign take = tok_valid_i && (tok_i.kind == npcl1_pkg::KIND_PIXEL) && active &&
                (!tok_i.found || (l1_dist < tok_i.best_dist));

  assign write_en = advance_i && tok_valid_i && (tok_i.kind == npcl1_pkg::KIND_LOAD) &&
                    (tok_i.entry_index == cell_id_i);

  always_comb begin
    tok_d = tok_i;
    if (take) begin
      tok_d.found     = 1'b1;
      tok_d.best_dist = l1_dist;
      tok_d.best_idx  = cell_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (write_en) begin
      entry_q <= tok_i.color;
    end
  end

  assign tok_valid_o = valid_q;
  assign tok_o       = tok_q;

endmodule

// File: src/nearest_palette_color_l1_top.sv
// ----------------------------------------------------------------------------
// Path: from the input transfer to the result, an item passes one register per
//   palette cell along the chain.
// Throughput: one item per cycle; the whole chain holds while a result waits.
// Loads travel the chain too and write their cell in order; they give no result.
// Reset clears the chain valid bits and sets the entry count (entries_q) to 256; the
//   palette itself is not cleared.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// nearest_palette_color_l1_top: nearest palette color search, L1 distance
// Systolic row of palette cells; each pixel picks up the closest entry on its way.
// ----------------------------------------------------------------------------
module nearest_palette_color_l1_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [npcl1_pkg::COUNT_W-1:0]     cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              kind_i,
  input  logic [npcl1_pkg::INDEX_W-1:0]     entry_index_i,
  input  logic [npcl1_pkg::CHAN_W-1:0]      red_i,
  input  logic [npcl1_pkg::CHAN_W-1:0]      green_i,
  input  logic [npcl1_pkg::CHAN_W-1:0]      blue_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [npcl1_pkg::INDEX_W-1:0]     color_index_o
);

  localparam int unsigned Depth = npcl1_pkg::PALETTE_DEPTH;

  logic [npcl1_pkg::COUNT_W-1:0] entries_q;
  logic                          advance;
  logic                          vld [Depth+1];
  npcl1_pkg::token_t             tok [Depth+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= npcl1_pkg::ENTRIES_RESET;
    end else if (cfg_we_i) begin
      entries_q <= cfg_wdata_i;
    end
  end

  // Last cell register doubles as the output register
  assign out_valid_o   = vld[Depth] && (tok[Depth].kind == npcl1_pkg::KIND_PIXEL);
  assign color_index_o = tok[Depth].best_idx;
  assign advance       = !out_valid_o || out_ready_i;
  assign in_ready_o    = advance;

  always_comb begin
    tok[0].kind        = npcl1_pkg::kind_e'(kind_i);
    tok[0].entry_index = entry_index_i;
    tok[0].color.red   = red_i;
    tok[0].color.green = green_i;
    tok[0].color.blue  = blue_i;
    tok[0].found       = 1'b0;
    tok[0].best_dist   = '0;
    tok[0].best_idx    = '0;
  end
  assign vld[0] = in_valid_i;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    npcl1_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .advance_i   (advance),
      .cell_id_i   (npcl1_pkg::INDEX_W'(i)),
      .entries_i   (entries_q),
      .tok_valid_i (vld[i]),
      .tok_i       (tok[i]),
      .tok_valid_o (vld[i+1]),
      .tok_o       (tok[i+1])
    );
  end

endmodule

// File: src/npcl1_checker.sv
// ----------------------------------------------------------------------------
// npcl1_checker: port-level checks for the nearest palette color search
// Watches the top level ports; bound to the top level below.
// ----------------------------------------------------------------------------
module npcl1_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              cfg_we_i,
  input logic [npcl1_pkg::COUNT_W-1:0]     cfg_wdata_i,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              kind_i,
  input logic [npcl1_pkg::INDEX_W-1:0]     entry_index_i,
  input logic [npcl1_pkg::CHAN_W-1:0]      red_i,
  input logic [npcl1_pkg::CHAN_W-1:0]      green_i,
  input logic [npcl1_pkg::CHAN_W-1:0]      blue_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [npcl1_pkg::INDEX_W-1:0]     color_index_o
);

  logic [npcl1_pkg::COUNT_W-1:0] entries_q;

  // shadow of the entry count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= npcl1_pkg::ENTRIES_RESET;
    end else if (cfg_we_i) begin
      entries_q <= cfg_wdata_i;
    end
  end

  // in the cycle after reset is seen, the chain is known to be empty
  a_no_result_in_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result shown during reset");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(color_index_o))
    else $error("stalled result changed");

  a_ready_follows_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready not tied to output space");

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (entries_q != '0) |-> ({1'b0, color_index_o} < entries_q))
    else $error("result index beyond searched entries");

  a_empty_search_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (entries_q == '0) |-> (color_index_o == '0))
    else $error("empty search gave nonzero index");

endmodule

bind nearest_palette_color_l1_top npcl1_checker u_npcl1_checker (.*);
